// ===== sv/y4m_sd_pkg.sv =====
package y4m_sd_pkg;

  localparam int DATA_W      = 8;
  localparam int FIELD_DIM_W = 14;
  localparam int LINE_W      = 24;
  localparam int TAG_IDX_W   = 4;

  localparam logic [LINE_W-1:0] LINE_MAX_RESET = 24'd8388608;

  localparam logic [DATA_W-1:0] ASCII_LF    = 8'h0a;
  localparam logic [DATA_W-1:0] ASCII_SPACE = 8'h20;
  localparam logic [DATA_W-1:0] ASCII_W     = 8'h57;
  localparam logic [DATA_W-1:0] ASCII_H     = 8'h48;
  localparam logic [DATA_W-1:0] ASCII_0     = 8'h30;
  localparam logic [DATA_W-1:0] ASCII_9     = 8'h39;

  // index of the final character of each tag
  localparam logic [TAG_IDX_W-1:0] STREAM_TAG_LAST = 4'd8;
  localparam logic [TAG_IDX_W-1:0] FRAME_TAG_LAST  = 4'd4;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_HALT    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_BAD_TAG = 2'd1,
    ERR_LINE    = 2'd2,
    ERR_DIM     = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    TK_NONE  = 2'd0,
    TK_W     = 2'd1,
    TK_H     = 2'd2,
    TK_START = 2'd3
  } token_t;

  localparam logic CFG_RUN_ENABLE = 1'b0;
  localparam logic CFG_MAX_LINE   = 1'b1;

  // "YUV4MPEG2"
  function automatic logic [DATA_W-1:0] stream_tag_char(input logic [TAG_IDX_W-1:0] idx);
    logic [DATA_W-1:0] c;
    case (idx)
      4'd0:    c = 8'h59;
      4'd1:    c = 8'h55;
      4'd2:    c = 8'h56;
      4'd3:    c = 8'h34;
      4'd4:    c = 8'h4d;
      4'd5:    c = 8'h50;
      4'd6:    c = 8'h45;
      4'd7:    c = 8'h47;
      default: c = 8'h32;
    endcase
    return c;
  endfunction

  // "FRAME"
  function automatic logic [DATA_W-1:0] frame_tag_char(input logic [TAG_IDX_W-1:0] idx);
    logic [DATA_W-1:0] c;
    case (idx)
      4'd0:    c = 8'h46;
      4'd1:    c = 8'h52;
      4'd2:    c = 8'h41;
      4'd3:    c = 8'h4d;
      default: c = 8'h45;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/y4m_stream_deframer_core.sv =====
// channel   direction  handshake                 payload
// in        sink       in_valid / in_stall       cmd, data_byte
// out       source     out_valid / out_stall     kind, pixel_byte, frame_first, frame_last,
//                                                frame_width, frame_height, error_code
// cfg       sink       cfg_wr_en                 cfg_index, cfg_data
//
// one byte per cycle while the output is not stalled: an input register feeds a single
// state update whose result lands in an output register.
// the payload size is kept up to date in two registered steps (multiply, then add)
// from the width and height, ready long before the FRAME line can end.
// rst is synchronous; it clears all parse state and drops both valid registers.
// a stalled output holds its result; the input register is stalled only while
// the output register is full and not being taken.
module y4m_stream_deframer_core #(
  parameter int MAX_DIM = 8192
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                cmd,
  input  logic [y4m_sd_pkg::DATA_W-1:0]       data_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          kind,
  output logic [y4m_sd_pkg::DATA_W-1:0]       pixel_byte,
  output logic                                frame_first,
  output logic                                frame_last,
  output logic [y4m_sd_pkg::FIELD_DIM_W-1:0]  frame_width,
  output logic [y4m_sd_pkg::FIELD_DIM_W-1:0]  frame_height,
  output logic [1:0]                          error_code,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_index,
  input  logic [y4m_sd_pkg::LINE_W-1:0]       cfg_data
);
  import y4m_sd_pkg::*;

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int ACC_W  = DIM_W + 4;
  localparam int AREA_W = 2 * DIM_W;
  localparam int SIZE_W = AREA_W + 1;
  localparam logic [ACC_W-1:0] MAX_DIM_V = ACC_W'(MAX_DIM);

  typedef enum logic [2:0] {
    PH_TAG, PH_HEADER, PH_FTAG, PH_FLINE, PH_PAYLOAD, PH_HALT
  } phase_t;

  // configuration
  logic              run_enable;
  logic [LINE_W-1:0] max_line_bytes;

  // input register
  logic              in_q_valid;
  logic              cmd_q;
  logic [DATA_W-1:0] data_q;

  // parse state
  phase_t               phase, phase_next;
  logic [TAG_IDX_W-1:0] tag_index, tag_index_next;
  token_t               token_kind, token_kind_next;
  logic [DIM_W-1:0]     number_accum, number_accum_next;
  logic [DIM_W-1:0]     width_reg, width_reg_next;
  logic [DIM_W-1:0]     height_reg, height_reg_next;
  logic [LINE_W-1:0]    line_count, line_count_next;
  logic [SIZE_W-1:0]    payload_left, payload_left_next;
  logic                 first_pending, first_pending_next;

  logic [AREA_W-1:0] area;
  logic [SIZE_W-1:0] frame_bytes;

  logic              advance;
  logic              proc_fire;
  logic              res_valid;
  kind_t             res_kind;
  logic [DATA_W-1:0] res_pixel;
  logic              res_first;
  logic              res_last;
  err_t              res_err;

  logic [LINE_W-1:0]    line_inc;
  logic                 is_stream;
  logic [TAG_IDX_W-1:0] tag_last;
  logic [TAG_IDX_W-1:0] tag_idx;
  logic [DATA_W-1:0]    tag_want;
  logic [ACC_W-1:0]     acc_new;
  logic                 is_digit;

  assign advance   = !out_valid || !out_stall;
  assign proc_fire = in_q_valid && advance;
  assign in_stall  = in_q_valid && !advance;

  assign line_inc  = (line_count != '1) ? line_count + 1'b1 : line_count;
  assign is_stream = (phase == PH_TAG);
  assign tag_last  = is_stream ? STREAM_TAG_LAST : FRAME_TAG_LAST;
  assign tag_idx   = (tag_index >= tag_last) ? tag_last : tag_index;
  assign tag_want  = is_stream ? stream_tag_char(tag_idx) : frame_tag_char(tag_idx);
  assign is_digit  = (data_q >= ASCII_0) && (data_q <= ASCII_9);
  // accum * 10 + digit
  assign acc_new   = (ACC_W'(number_accum) << 3) + (ACC_W'(number_accum) << 1)
                     + ACC_W'(data_q[3:0]);

  always_comb begin
    phase_next         = phase;
    tag_index_next     = tag_index;
    token_kind_next    = token_kind;
    number_accum_next  = number_accum;
    width_reg_next     = width_reg;
    height_reg_next    = height_reg;
    line_count_next    = line_count;
    payload_left_next  = payload_left;
    first_pending_next = first_pending;
    res_valid = 1'b0;
    res_kind  = KIND_PAYLOAD;
    res_pixel = '0;
    res_first = 1'b0;
    res_last  = 1'b0;
    res_err   = ERR_NONE;

    if (proc_fire) begin
      if (cmd_q) begin
        phase_next         = PH_TAG;
        tag_index_next     = '0;
        token_kind_next    = TK_NONE;
        number_accum_next  = '0;
        width_reg_next     = '0;
        height_reg_next    = '0;
        line_count_next    = '0;
        payload_left_next  = '0;
        first_pending_next = 1'b0;
      end else if (run_enable && phase != PH_HALT) begin
        if (phase == PH_PAYLOAD) begin
          res_valid          = 1'b1;
          res_pixel          = data_q;
          res_first          = first_pending;
          res_last           = (payload_left <= SIZE_W'(1));
          first_pending_next = 1'b0;
          if (payload_left <= SIZE_W'(1)) begin
            payload_left_next = '0;
            phase_next        = PH_FTAG;
            tag_index_next    = '0;
            line_count_next   = '0;
          end else begin
            payload_left_next = payload_left - 1'b1;
          end
        end else if (data_q != ASCII_LF && line_inc > max_line_bytes) begin
          line_count_next = line_inc;
          phase_next      = PH_HALT;
          res_valid       = 1'b1;
          res_kind        = KIND_HALT;
          res_err         = ERR_LINE;
        end else begin
          if (data_q != ASCII_LF) begin
            line_count_next = line_inc;
          end
          unique case (phase)
            PH_TAG, PH_FTAG: begin
              if (data_q != tag_want) begin
                phase_next = PH_HALT;
                res_valid  = 1'b1;
                res_kind   = KIND_HALT;
                res_err    = ERR_BAD_TAG;
              end else if (tag_idx == tag_last) begin
                tag_index_next  = '0;
                token_kind_next = TK_NONE;
                phase_next      = is_stream ? PH_HEADER : PH_FLINE;
              end else begin
                tag_index_next = tag_idx + 1'b1;
              end
            end
            PH_HEADER: begin
              if (data_q == ASCII_LF) begin
                phase_next      = PH_FTAG;
                tag_index_next  = '0;
                line_count_next = '0;
                token_kind_next = TK_NONE;
              end else if (data_q == ASCII_SPACE) begin
                token_kind_next = TK_START;
              end else if (token_kind == TK_START) begin
                token_kind_next   = (data_q == ASCII_W) ? TK_W :
                                    (data_q == ASCII_H) ? TK_H : TK_NONE;
                number_accum_next = '0;
              end else if (token_kind == TK_W || token_kind == TK_H) begin
                if (!is_digit) begin
                  token_kind_next = TK_NONE;
                end else if (acc_new > MAX_DIM_V) begin
                  phase_next = PH_HALT;
                  res_valid  = 1'b1;
                  res_kind   = KIND_HALT;
                  res_err    = ERR_DIM;
                end else begin
                  number_accum_next = DIM_W'(acc_new);
                  if (token_kind == TK_W) begin
                    width_reg_next = DIM_W'(acc_new);
                  end else begin
                    height_reg_next = DIM_W'(acc_new);
                  end
                end
              end
            end
            PH_FLINE: begin
              // rest of the FRAME line is skipped
              if (data_q == ASCII_LF) begin
                line_count_next = '0;
                tag_index_next  = '0;
                if (frame_bytes == '0) begin
                  phase_next = PH_FTAG;
                  res_valid  = 1'b1;
                  res_kind   = KIND_EMPTY;
                end else begin
                  payload_left_next  = frame_bytes;
                  first_pending_next = 1'b1;
                  phase_next         = PH_PAYLOAD;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  // frame size = area + 2*floor(area/4), tracked from the dimension registers
  always_ff @(posedge clk) begin
    area        <= AREA_W'(width_reg) * AREA_W'(height_reg);
    frame_bytes <= SIZE_W'(area) + (SIZE_W'(area >> 2) << 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_enable     <= 1'b0;
      max_line_bytes <= LINE_MAX_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_RUN_ENABLE) begin
        run_enable <= cfg_data[0];
      end else begin
        max_line_bytes <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      cmd_q  <= cmd;
      data_q <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TAG;
      tag_index     <= '0;
      token_kind    <= TK_NONE;
      number_accum  <= '0;
      width_reg     <= '0;
      height_reg    <= '0;
      line_count    <= '0;
      payload_left  <= '0;
      first_pending <= 1'b0;
    end else begin
      phase         <= phase_next;
      tag_index     <= tag_index_next;
      token_kind    <= token_kind_next;
      number_accum  <= number_accum_next;
      width_reg     <= width_reg_next;
      height_reg    <= height_reg_next;
      line_count    <= line_count_next;
      payload_left  <= payload_left_next;
      first_pending <= first_pending_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end
    if (advance && res_valid) begin
      kind         <= res_kind;
      pixel_byte   <= res_pixel;
      frame_first  <= res_first;
      frame_last   <= res_last;
      frame_width  <= FIELD_DIM_W'(width_reg);
      frame_height <= FIELD_DIM_W'(height_reg);
      error_code   <= res_err;
    end
  end

endmodule
